// File: design/ecwd_pkg.sv
// ----------------------------------------------------------------------------
// ecwd_pkg
// Shared word type codes and the command record passed from the front end
// to the back end of the event camera word decoder.
// ----------------------------------------------------------------------------
package ecwd_pkg;

	localparam logic [3:0] TYPE_ROW   = 4'h0;
	localparam logic [3:0] TYPE_COL   = 4'h2;
	localparam logic [3:0] TYPE_VBASE = 4'h3;
	localparam logic [3:0] TYPE_V12   = 4'h4;
	localparam logic [3:0] TYPE_V8    = 4'h5;
	localparam logic [3:0] TYPE_TLOW  = 4'h6;
	localparam logic [3:0] TYPE_THIGH = 4'h8;
	localparam logic [3:0] TYPE_TRIG  = 4'hA;

	localparam int MASK_W = 12;

	typedef struct packed {
		logic              kind;
		logic [31:0]       time_res;
		logic [15:0]       base;
		logic [10:0]       row;
		logic              polarity;
		logic [3:0]        trig_chan;
		logic [MASK_W-1:0] mask;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: design/event_camera_word_decoder.sv
// ----------------------------------------------------------------------------
// event_camera_word_decoder
// Decodes a stream of 16-bit event camera words into pixel and trigger events.
//
// Input channel word_valid/word_ready carries one stream word per transaction.
// Output channel res_valid/res_ready carries one event per transaction; last
// marks the final event caused by one word. Words that cause no event
// (row, time, vector base, unknown types) produce no output transaction.
// An accepted word passes through the command queue, the current command
// register of the back end and the output register before its first event
// shows. Words causing at most one event are taken one per cycle while
// res_ready stays high. A vector word gives one event per set bit. The
// front end keeps accepting words while the QUEUE_DEPTH-entry command queue
// has room and drops word_ready when it is full. When the receiver stalls,
// the output register holds its event and the back end, then the queue,
// then the input fill up in turn. Reset clears all decoder state (time, row,
// vector group) and empties the queue and the output register.
// ----------------------------------------------------------------------------
module event_camera_word_decoder import ecwd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_ready,
	input  logic [15:0] word,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [31:0] time_res,
	output logic [15:0] column,
	output logic [10:0] row,
	output logic        polarity,
	output logic [3:0]  trig_chan,
	output logic        last
);

	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;
	logic    busy;

	ecwd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (push_cmd)
	);

	ecwd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	ecwd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.busy      (busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.time_res  (time_res),
		.column    (column),
		.row       (row),
		.polarity  (polarity),
		.trig_chan (trig_chan),
		.last      (last)
	);

	a_trig_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind) |-> (row == '0 && column == '0 && last))
		else $error("trigger transaction carries pixel fields");

	a_pix_tid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !kind) |-> (trig_chan == '0))
		else $error("pixel transaction carries a trigger channel");

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> busy)
		else $error("command queue full while back end is idle");

	a_no_bad_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty command queue");

endmodule

// File: design/ecwd_front.sv
// ----------------------------------------------------------------------------
// ecwd_front
// Accepts stream words, keeps the time, row and vector group state, and
// turns every word that produces events into one command.
// ----------------------------------------------------------------------------
module ecwd_front import ecwd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_ready,
	input  logic [15:0] word,
	input  q_stat_t     q_stat,
	output logic        push,
	output cmd_t        cmd
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ONE  = 3'b010,
		PH_TWO  = 3'b100
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  wrap_q, wrap_d;
	logic [11:0] thigh_q, thigh_d;
	logic [31:0] time_q, time_d;
	logic [10:0] row_q, row_d;
	logic [15:0] base_q, base_d;
	logic        vpol_q, vpol_d;

	logic [3:0]  typ;
	logic [11:0] data;
	logic        cont;
	logic        acc;
	logic        push_c;
	logic [15:0] base_cl;
	phase_t      phase_cl;

	assign word_ready = !q_stat.full;
	assign acc        = word_valid && word_ready;
	assign typ        = word[15:12];
	assign data       = word[11:0];
	assign push       = acc && push_c;

	always_comb begin
		cont = ((typ == TYPE_V12) && (phase_q == PH_ONE)) ||
		       ((typ == TYPE_V8) && (phase_q == PH_TWO));
		if ((phase_q != PH_IDLE) && !cont) begin
			base_cl  = base_q + 16'd32;
			phase_cl = PH_IDLE;
		end else begin
			base_cl  = base_q;
			phase_cl = phase_q;
		end

		phase_d = phase_cl;
		base_d  = base_cl;
		wrap_d  = wrap_q;
		thigh_d = thigh_q;
		time_d  = time_q;
		row_d   = row_q;
		vpol_d  = vpol_q;
		push_c  = 1'b0;

		cmd.kind      = 1'b0;
		cmd.time_res  = time_q;
		cmd.base      = '0;
		cmd.row       = row_q;
		cmd.polarity  = 1'b0;
		cmd.trig_chan = '0;
		cmd.mask      = '0;

		unique case (typ)
			TYPE_ROW: begin
				row_d = data[10:0];
			end
			TYPE_COL: begin
				cmd.base     = {5'd0, data[10:0]};
				cmd.polarity = data[11];
				cmd.mask     = MASK_W'(1);
				push_c       = 1'b1;
			end
			TYPE_VBASE: begin
				base_d = {5'd0, data[10:0]};
				vpol_d = data[11];
			end
			TYPE_V12: begin
				if (phase_q == PH_ONE) begin
					cmd.base = base_q + 16'd12;
					phase_d  = PH_TWO;
				end else begin
					cmd.base = base_cl;
					phase_d  = PH_ONE;
				end
				cmd.polarity = vpol_q;
				cmd.mask     = data;
				push_c       = |data;
			end
			TYPE_V8: begin
				if (phase_q == PH_TWO) begin
					cmd.base     = base_q + 16'd24;
					cmd.polarity = vpol_q;
					cmd.mask     = {4'd0, data[7:0]};
					push_c       = |data[7:0];
					base_d       = base_q + 16'd32;
					phase_d      = PH_IDLE;
				end
			end
			TYPE_TLOW: begin
				time_d = {wrap_q, thigh_q, data};
			end
			TYPE_THIGH: begin
				if (data < thigh_q) begin
					wrap_d = wrap_q + 8'd1;
				end
				thigh_d = data;
			end
			TYPE_TRIG: begin
				cmd.kind      = 1'b1;
				cmd.row       = '0;
				cmd.polarity  = data[0];
				cmd.trig_chan = data[11:8];
				cmd.mask      = MASK_W'(1);
				push_c        = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wrap_q  <= '0;
			thigh_q <= '0;
			time_q  <= '0;
			row_q   <= '0;
			base_q  <= '0;
			vpol_q  <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			wrap_q  <= wrap_d;
			thigh_q <= thigh_d;
			time_q  <= time_d;
			row_q   <= row_d;
			base_q  <= base_d;
			vpol_q  <= vpol_d;
		end
	end

endmodule

// File: design/ecwd_fifo.sv
// ----------------------------------------------------------------------------
// ecwd_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ecwd_fifo import ecwd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/ecwd_back.sv
// ----------------------------------------------------------------------------
// ecwd_back
// Expands one command into result transactions, one per set mask bit in
// ascending order, through a registered output stage.
// ----------------------------------------------------------------------------
module ecwd_back import ecwd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        busy,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [31:0] time_res,
	output logic [15:0] column,
	output logic [10:0] row,
	output logic        polarity,
	output logic [3:0]  trig_chan,
	output logic        last
);

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic              res_valid_q;

	logic [MASK_W-1:0] lsb;
	logic [MASK_W-1:0] rest;
	logic [3:0]        idx;
	logic              adv;
	logic              done;

	always_comb begin
		lsb  = mask_q & (~mask_q + 1'b1);
		rest = mask_q & (mask_q - 1'b1);
		idx  = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (lsb[i]) begin
				idx = idx | 4'(i);
			end
		end
	end

	assign adv       = cur_valid_q && (!res_valid_q || res_ready);
	assign done      = adv && (rest == '0);
	assign pop       = !q_stat.empty && (!cur_valid_q || done);
	assign busy      = cur_valid_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= head;
			mask_q <= head.mask;
		end else if (adv) begin
			mask_q <= rest;
		end
		if (adv) begin
			kind      <= cur_q.kind;
			time_res  <= cur_q.time_res;
			column    <= cur_q.base + {12'd0, idx};
			row       <= cur_q.row;
			polarity  <= cur_q.polarity;
			trig_chan <= cur_q.trig_chan;
			last      <= (rest == '0);
		end
	end

endmodule

// File: tb/event_camera_word_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_camera_word_decoder_tb
// Feeds the decoder a directed burst of stream words and then random traffic
// built mostly from complete vector groups and time pairs. A scoreboard
// predicts the events of each accepted word and checks every result
// transaction in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module event_camera_word_decoder_tb;
	import ecwd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_WORDS = 140;
	localparam bit KIND_PIXEL = 1'b0;
	localparam bit KIND_TRIGGER = 1'b1;

	typedef enum logic [1:0] {GROUP_IDLE, GROUP_FIRST, GROUP_SECOND} group_phase_t;

	typedef struct {
		bit        kind;
		bit [31:0] time_res;
		bit [15:0] column;
		bit [10:0] row;
		bit        polarity;
		bit [3:0]  trig_chan;
		bit        last;
	} event_rec_t;

	class event_scoreboard;
		event_rec_t   pending_events[$];
		int           errors;
		bit [7:0]     wraps;
		bit [23:0]    time_high;
		bit [31:0]    cur_time;
		bit [10:0]    cur_row;
		bit [15:0]    base;
		bit           vec_pol;
		group_phase_t phase;

		function new();
			errors = 0;
			wraps = '0;
			time_high = '0;
			cur_time = '0;
			cur_row = '0;
			base = '0;
			vec_pol = 1'b0;
			phase = GROUP_IDLE;
		endfunction

		function int pending();
			return pending_events.size();
		endfunction

		function void push_event(bit kind, bit [15:0] column, bit [10:0] row, bit pol,
				bit [3:0] tid);
			event_rec_t rec;
			rec.kind = kind;
			rec.time_res = cur_time;
			rec.column = column;
			rec.row = row;
			rec.polarity = pol;
			rec.trig_chan = tid;
			rec.last = 1'b0;
			pending_events.push_back(rec);
		endfunction

		function void push_vector(bit [11:0] bits, int nbits, int offset);
			for (int i = 0; i < nbits; i++) begin
				if (bits[i])
					push_event(KIND_PIXEL, base + 16'(offset + i), cur_row, vec_pol, 4'd0);
			end
		endfunction

		function void note_word(bit [15:0] w);
			bit [3:0]  wtype;
			bit [11:0] data;
			bit [23:0] new_high;
			bit        joins;
			int        n_prior;
			event_rec_t rec;
			wtype = w[15:12];
			data = w[11:0];
			n_prior = pending_events.size();
			joins = (wtype == TYPE_V12 && phase == GROUP_FIRST) ||
				(wtype == TYPE_V8 && phase == GROUP_SECOND);
			if (phase != GROUP_IDLE && !joins) begin
				base = base + 16'd32;
				phase = GROUP_IDLE;
			end
			case (wtype)
				TYPE_ROW: cur_row = data[10:0];
				TYPE_COL: push_event(KIND_PIXEL, {5'b0, data[10:0]}, cur_row, data[11], 4'd0);
				TYPE_VBASE: begin
					base = {5'b0, data[10:0]};
					vec_pol = data[11];
				end
				TYPE_V12: begin
					if (phase == GROUP_FIRST) begin
						push_vector(data, 12, 12);
						phase = GROUP_SECOND;
					end else begin
						push_vector(data, 12, 0);
						phase = GROUP_FIRST;
					end
				end
				TYPE_V8: begin
					if (phase == GROUP_SECOND) begin
						push_vector({4'b0, data[7:0]}, 8, 24);
						base = base + 16'd32;
						phase = GROUP_IDLE;
					end
				end
				TYPE_TLOW: cur_time = {wraps, time_high} | {20'b0, data};
				TYPE_THIGH: begin
					new_high = {data, 12'b0};
					if (new_high < time_high)
						wraps = wraps + 8'd1;
					time_high = new_high;
				end
				TYPE_TRIG: push_event(KIND_TRIGGER, 16'd0, 11'd0, data[0], data[11:8]);
				default: ;
			endcase
			if (pending_events.size() > n_prior) begin
				rec = pending_events.pop_back();
				rec.last = 1'b1;
				pending_events.push_back(rec);
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_event(event_rec_t got);
			event_rec_t exp;
			if (pending_events.size() == 0) begin
				report_mismatch("result transaction with no event expected");
			end else begin
				exp = pending_events.pop_front();
				if (got.kind != exp.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", got.kind, exp.kind));
				if (got.time_res != exp.time_res)
					report_mismatch($sformatf("time_res %h, expected %h", got.time_res,
						exp.time_res));
				if (got.column != exp.column)
					report_mismatch($sformatf("column %h, expected %h", got.column, exp.column));
				if (got.row != exp.row)
					report_mismatch($sformatf("row %h, expected %h", got.row, exp.row));
				if (got.polarity != exp.polarity)
					report_mismatch($sformatf("polarity %0d, expected %0d", got.polarity,
						exp.polarity));
				if (got.trig_chan != exp.trig_chan)
					report_mismatch($sformatf("trig_chan %h, expected %h", got.trig_chan,
						exp.trig_chan));
				if (got.last != exp.last)
					report_mismatch($sformatf("last %0d, expected %0d", got.last, exp.last));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        word_valid = 1'b0;
	logic        word_ready;
	logic [15:0] word = 16'h0000;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        kind;
	logic [31:0] time_res;
	logic [15:0] column;
	logic [10:0] row;
	logic        polarity;
	logic [3:0]  trig_chan;
	logic        last;

	event_scoreboard scoreboard = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int stall_left = 0;
	int cycle_count = 0;

	event_camera_word_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word(word),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.kind(kind),
		.time_res(time_res),
		.column(column),
		.row(row),
		.polarity(polarity),
		.trig_chan(trig_chan),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[event_camera_word_decoder] ERROR");
			$finish;
		end
	end

	function int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		event_rec_t got;
		if (arst_n && res_valid && res_ready) begin
			got.kind = kind;
			got.time_res = time_res;
			got.column = column;
			got.row = row;
			got.polarity = polarity;
			got.trig_chan = trig_chan;
			got.last = last;
			scoreboard.check_event(got);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 3) == 0) begin
			stall_left <= idle_length() - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	function bit [11:0] random_mask();
		case ($urandom_range(0, 3))
			0: return 12'hFFF;
			1: return 12'($urandom_range(0, 4095) & $urandom_range(0, 4095));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	task send_word(bit [15:0] w);
		int gap;
		gap = 0;
		if (tx_idle && $urandom_range(0, 99) >= 60)
			gap = idle_length();
		if (gap > 0) begin
			word_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_valid <= 1'b1;
		word <= w;
		do @(posedge clk); while (!word_ready);
		scoreboard.note_word(w);
	endtask

	task drain_events();
		word_valid <= 1'b0;
		do @(posedge clk); while (scoreboard.pending() != 0);
	endtask

	initial begin
		int made;
		int next_mode_at;
		int pick;
		bit paused;
		bit [3:0] noise_types[6];
		noise_types = '{4'h1, 4'h7, 4'h9, 4'hB, 4'hD, 4'hF};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word({TYPE_ROW, 12'hFFF});
		send_word({TYPE_THIGH, 12'hFFF});
		send_word({TYPE_TLOW, 12'hFFF});
		send_word({TYPE_COL, 12'hFFF});
		send_word({TYPE_COL, 12'h000});
		send_word({TYPE_TRIG, 12'hF01});
		send_word({TYPE_THIGH, 12'h001});
		send_word({TYPE_TLOW, 12'h000});
		send_word({TYPE_VBASE, 12'hFFF});
		send_word({TYPE_V12, 12'hFFF});
		send_word({TYPE_V12, 12'hFFF});
		send_word({TYPE_V8, 12'hFFF});
		send_word({TYPE_V12, 12'h000});
		send_word({TYPE_ROW, 12'h000});
		send_word({TYPE_V8, 12'hA5A});
		send_word({TYPE_V12, 12'h801});
		send_word({TYPE_V8, 12'h080});
		send_word({TYPE_V12, 12'h002});
		send_word({TYPE_V12, 12'h400});
		send_word({TYPE_V12, 12'h003});
		send_word({4'h1, 12'hFFF});
		send_word({4'h7, 12'h000});
		send_word({4'h9, 12'hABC});
		send_word({4'hF, 12'h555});
		send_word({TYPE_TRIG, 12'h000});

		made = 0;
		next_mode_at = 40;
		paused = 1'b0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (made < RANDOM_WORDS) begin
			if (made >= next_mode_at) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
				next_mode_at += 40;
			end
			if (!paused && made >= RANDOM_WORDS / 2) begin
				drain_events();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_word({TYPE_VBASE, 12'($urandom_range(0, 4095))});
				send_word({TYPE_V12, random_mask()});
				made += 2;
				if ($urandom_range(0, 99) < 80) begin
					send_word({TYPE_V12, random_mask()});
					made++;
					if ($urandom_range(0, 99) < 75) begin
						send_word({TYPE_V8, random_mask()});
						made++;
					end
				end
			end else if (pick < 58) begin
				send_word({TYPE_THIGH, 12'($urandom_range(0, 4095))});
				send_word({TYPE_TLOW, 12'($urandom_range(0, 4095))});
				made += 2;
			end else if (pick < 66) begin
				send_word({TYPE_ROW, 12'($urandom_range(0, 4095))});
				made++;
			end else if (pick < 76) begin
				send_word({TYPE_COL, 12'($urandom_range(0, 4095))});
				made++;
			end else if (pick < 84) begin
				send_word({TYPE_TRIG, 12'($urandom_range(0, 4095))});
				made++;
			end else if (pick < 90) begin
				send_word({$urandom_range(0, 1) ? TYPE_V12 : TYPE_V8, random_mask()});
				made++;
			end else if (pick < 95) begin
				send_word({noise_types[$urandom_range(0, 5)], 12'($urandom_range(0, 4095))});
			end else begin
				send_word(16'($urandom_range(0, 65535)));
				made++;
			end
		end

		drain_events();
		repeat (20) @(posedge clk);
		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("[event_camera_word_decoder] OK");
		else
			$display("[event_camera_word_decoder] ERROR");
		$finish;
	end

endmodule

// File: event_camera_word_decoder.f
design/ecwd_pkg.sv
design/ecwd_front.sv
design/ecwd_fifo.sv
design/ecwd_back.sv
design/event_camera_word_decoder.sv
tb/event_camera_word_decoder_tb.sv
